// ----- hdl/assert_macros.svh -----
// assertion helpers shared by the rtl files
// every user provides clk and rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define GEM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define GEM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/gem_pkg.sv -----
// ----------------------------------------------------------------------------
// gem_pkg
// shared types, widths and codes of the grid edge index mapper
// ----------------------------------------------------------------------------
`default_nettype none

package gem_pkg;

  localparam int MAX_LEN = 256;
  localparam int LEN_W   = 9;          // length register width
  localparam int CRD_W   = 8;          // coordinate width
  localparam int IDX_W   = 26;         // index port width
  localparam int PROD_W  = 2 * CRD_W + 1;  // product of two lengths
  localparam int NUM_W   = 3 * CRD_W + 1;  // product of three lengths
  localparam int OFF_W   = 3 * CRD_W;      // in-range offset into a bin
  localparam int Q1_W    = 2 * CRD_W;      // quotient bits of first divide
  localparam int Q2_W    = CRD_W;          // quotient bits of second divide
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEN_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEN_Z = 2'd2;

  // actions
  localparam logic [1:0] ACT_C2V = 2'd0;
  localparam logic [1:0] ACT_V2C = 2'd1;
  localparam logic [1:0] ACT_E2P = 2'd2;
  localparam logic [1:0] ACT_P2E = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOT_ADJ = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  // axis codes
  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  typedef struct packed {
    logic [LEN_W-1:0] x;
    logic [LEN_W-1:0] y;
    logic [LEN_W-1:0] z;
  } gem_lens_t;

  typedef struct packed {
    logic [1:0]       action;
    logic [1:0]       status;
    logic [IDX_W-1:0] index_out;
    logic [1:0]       axis;
    logic [LEN_W-1:0] r0;
    logic [LEN_W-1:0] r1;
  } gem_tag_t;

  typedef struct packed {
    gem_tag_t         tag;
    logic [OFF_W-1:0] off;
  } gem_item_t;

  typedef struct packed {
    gem_tag_t         tag;
    logic [CRD_W-1:0] c0;
    logic [CRD_W-1:0] c1;
    logic [CRD_W-1:0] c2;
  } gem_coord_t;

  // zero acts as one, anything above the maximum acts as the maximum
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = LEN_W'(1);
    end else if (v > LEN_W'(MAX_LEN)) begin
      r = LEN_W'(MAX_LEN);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/gem_front.sv -----
// ----------------------------------------------------------------------------
// gem_front
// four-stage front end: range checks, grid products, encode, bin select
// ----------------------------------------------------------------------------
`default_nettype none

module gem_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire logic [1:0]                    action,
  input  wire logic [gem_pkg::IDX_W-1:0]     index_in,
  input  wire logic [gem_pkg::CRD_W-1:0]     a_x,
  input  wire logic [gem_pkg::CRD_W-1:0]     a_y,
  input  wire logic [gem_pkg::CRD_W-1:0]     a_z,
  input  wire logic [gem_pkg::CRD_W-1:0]     b_x,
  input  wire logic [gem_pkg::CRD_W-1:0]     b_y,
  input  wire logic [gem_pkg::CRD_W-1:0]     b_z,
  input  wire gem_pkg::gem_lens_t            lens,
  output logic                               item_valid,
  output gem_pkg::gem_item_t                 item
);

`include "assert_macros.svh"

  localparam int LEN_W  = gem_pkg::LEN_W;
  localparam int CRD_W  = gem_pkg::CRD_W;
  localparam int IDX_W  = gem_pkg::IDX_W;
  localparam int PROD_W = gem_pkg::PROD_W;
  localparam int NUM_W  = gem_pkg::NUM_W;
  localparam int OFF_W  = gem_pkg::OFF_W;

  // ---- stage 1 inputs
  gem_pkg::gem_lens_t l, lm;
  logic ok_a, ok_b, nzx, nzy, nzz, ux, uy, uz, adj, is_p2e;
  logic [1:0] axis3, st1;
  logic [CRD_W-1:0] cx, cy, cz;
  logic [LEN_W-1:0] re0, re1;

  assign l.x  = gem_pkg::eff_len(lens.x);
  assign l.y  = gem_pkg::eff_len(lens.y);
  assign l.z  = gem_pkg::eff_len(lens.z);
  assign lm.x = l.x - LEN_W'(1);
  assign lm.y = l.y - LEN_W'(1);
  assign lm.z = l.z - LEN_W'(1);

  assign ok_a = ({1'b0, a_x} < l.x) && ({1'b0, a_y} < l.y) && ({1'b0, a_z} < l.z);
  assign ok_b = ({1'b0, b_x} < l.x) && ({1'b0, b_y} < l.y) && ({1'b0, b_z} < l.z);
  assign nzx  = a_x != b_x;
  assign nzy  = a_y != b_y;
  assign nzz  = a_z != b_z;
  assign ux   = (({1'b0, a_x} + LEN_W'(1)) == {1'b0, b_x}) ||
                (({1'b0, b_x} + LEN_W'(1)) == {1'b0, a_x});
  assign uy   = (({1'b0, a_y} + LEN_W'(1)) == {1'b0, b_y}) ||
                (({1'b0, b_y} + LEN_W'(1)) == {1'b0, a_y});
  assign uz   = (({1'b0, a_z} + LEN_W'(1)) == {1'b0, b_z}) ||
                (({1'b0, b_z} + LEN_W'(1)) == {1'b0, a_z});
  assign adj  = (ux && !nzy && !nzz) || (uy && !nzx && !nzz) || (uz && !nzx && !nzy);
  assign axis3 = nzz ? gem_pkg::AX_Z : (nzy ? gem_pkg::AX_Y : gem_pkg::AX_X);
  assign is_p2e = action == gem_pkg::ACT_P2E;

  // adjacent pair: the lower vertex is the per-axis minimum
  assign cx = (is_p2e && b_x < a_x) ? b_x : a_x;
  assign cy = (is_p2e && b_y < a_y) ? b_y : a_y;
  assign cz = (is_p2e && b_z < a_z) ? b_z : a_z;
  assign re0 = (is_p2e && axis3 == gem_pkg::AX_X) ? lm.x : l.x;
  assign re1 = (is_p2e && axis3 == gem_pkg::AX_Y) ? lm.y : l.y;

  always_comb begin
    st1 = gem_pkg::ST_OK;
    if (action == gem_pkg::ACT_C2V) begin
      if (!ok_a) st1 = gem_pkg::ST_RANGE;
    end else if (is_p2e) begin
      if (!(ok_a && ok_b)) st1 = gem_pkg::ST_RANGE;
      else if (!adj) st1 = gem_pkg::ST_NOT_ADJ;
    end
  end

  // ---- stage 1 registers
  logic s1_valid;
  logic [1:0] s1_action, s1_status, s1_axis;
  logic [IDX_W-1:0] s1_idx;
  gem_pkg::gem_lens_t s1_l, s1_lm;
  logic [CRD_W-1:0] s1_cx;
  logic [LEN_W-1:0] s1_re0;
  logic [PROD_W-1:0] s1_tmul, s1_p01, s1_pa, s1_pb;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else s1_valid <= accept;
  end

  always_ff @(posedge clk) begin
    s1_action <= action;
    s1_status <= st1;
    s1_axis   <= axis3;
    s1_idx    <= index_in;
    s1_l      <= l;
    s1_lm     <= lm;
    s1_cx     <= cx;
    s1_re0    <= re0;
    s1_tmul   <= PROD_W'(cz) * PROD_W'(re1) + PROD_W'(cy);
    s1_p01    <= PROD_W'(l.x) * PROD_W'(l.y);
    s1_pa     <= PROD_W'(lm.x) * PROD_W'(l.y);
    s1_pb     <= PROD_W'(l.x) * PROD_W'(lm.y);
  end

  // ---- stage 2: vertex count, edge counts per axis, mixed-radix encode
  logic s2_valid;
  logic [1:0] s2_action, s2_status, s2_axis;
  logic [IDX_W-1:0] s2_idx;
  gem_pkg::gem_lens_t s2_l, s2_lm;
  logic [NUM_W-1:0] s2_n, s2_e0, s2_e1, s2_e2, s2_enc;

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else s2_valid <= s1_valid;
  end

  always_ff @(posedge clk) begin
    s2_action <= s1_action;
    s2_status <= s1_status;
    s2_axis   <= s1_axis;
    s2_idx    <= s1_idx;
    s2_l      <= s1_l;
    s2_lm     <= s1_lm;
    s2_n      <= NUM_W'(s1_p01) * NUM_W'(s1_l.z);
    s2_e0     <= NUM_W'(s1_pa) * NUM_W'(s1_l.z);
    s2_e1     <= NUM_W'(s1_pb) * NUM_W'(s1_l.z);
    s2_e2     <= NUM_W'(s1_p01) * NUM_W'(s1_lm.z);
    s2_enc    <= NUM_W'(s1_cx) + NUM_W'(s1_re0) * NUM_W'(s1_tmul);
  end

  // ---- stage 3: edge bin offsets, totals, first bin compare
  logic [IDX_W-1:0] esum;

  always_comb begin
    case (s2_axis)
      gem_pkg::AX_Y: esum = IDX_W'(s2_e0);
      gem_pkg::AX_Z: esum = IDX_W'(s2_e0) + IDX_W'(s2_e1);
      default:       esum = '0;
    endcase
  end

  logic s3_valid, s3_ge0, s3_ok1;
  logic [1:0] s3_action, s3_status;
  logic [IDX_W-1:0] s3_idx, s3_d1, s3_total, s3_res, s3_e1;
  gem_pkg::gem_lens_t s3_l, s3_lm;

  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else s3_valid <= s2_valid;
  end

  always_ff @(posedge clk) begin
    s3_action <= s2_action;
    s3_status <= s2_status;
    s3_idx    <= s2_idx;
    s3_l      <= s2_l;
    s3_lm     <= s2_lm;
    s3_e1     <= IDX_W'(s2_e1);
    s3_ge0    <= s2_idx >= IDX_W'(s2_e0);
    s3_d1     <= s2_idx - IDX_W'(s2_e0);
    s3_ok1    <= s2_idx < IDX_W'(s2_n);
    s3_total  <= IDX_W'(s2_e0) + IDX_W'(s2_e1) + IDX_W'(s2_e2);
    s3_res    <= (s2_action == gem_pkg::ACT_P2E) ? IDX_W'(s2_enc) + esum
                                                 : IDX_W'(s2_enc);
  end

  // ---- stage 4: bin pick, divisors, final status
  gem_pkg::gem_item_t nx;

  always_comb begin
    nx.tag.action    = s3_action;
    nx.tag.status    = s3_status;
    nx.tag.index_out = '0;
    nx.tag.axis      = gem_pkg::AX_X;
    nx.tag.r0        = s3_l.x;
    nx.tag.r1        = s3_l.y;
    nx.off           = OFF_W'(s3_idx);
    case (s3_action)
      gem_pkg::ACT_V2C: begin
        if (!s3_ok1) nx.tag.status = gem_pkg::ST_RANGE;
      end
      gem_pkg::ACT_E2P: begin
        if (!(s3_idx < s3_total)) nx.tag.status = gem_pkg::ST_RANGE;
        if (!s3_ge0) begin
          nx.tag.r0 = s3_lm.x;
        end else if (s3_d1 >= s3_e1) begin
          nx.tag.axis = gem_pkg::AX_Z;
          nx.off      = OFF_W'(s3_d1 - s3_e1);
        end else begin
          nx.tag.axis = gem_pkg::AX_Y;
          nx.tag.r1   = s3_lm.y;
          nx.off      = OFF_W'(s3_d1);
        end
      end
      default: begin
        if (s3_status == gem_pkg::ST_OK) nx.tag.index_out = s3_res;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) item_valid <= 1'b0;
    else item_valid <= s3_valid;
  end

  always_ff @(posedge clk) begin
    item <= nx;
  end

  `GEM_ASSERT_IMP(a_not_adj_only_p2e, item_valid && item.tag.status == gem_pkg::ST_NOT_ADJ, item.tag.action == gem_pkg::ACT_P2E, "non-adjacent status on an action other than endpoints to edge")

endmodule

`default_nettype wire

// ----- hdl/gem_decode.sv -----
// ----------------------------------------------------------------------------
// gem_decode
// pipelined restoring divide: offset splits into three mixed-radix digits
// ----------------------------------------------------------------------------
`default_nettype none

module gem_decode (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  input  wire gem_pkg::gem_item_t  item,
  output logic                     crd_valid,
  output gem_pkg::gem_coord_t      crd
);

  localparam int CRD_W = gem_pkg::CRD_W;
  localparam int Q1_W  = gem_pkg::Q1_W;
  localparam int Q2_W  = gem_pkg::Q2_W;

  // first divide by r0: one quotient bit per stage
  logic [Q1_W-1:0]  d1_valid;
  gem_pkg::gem_tag_t d1_tag [Q1_W];
  logic [CRD_W-1:0] d1_rem [Q1_W];
  logic [Q1_W-1:0]  d1_q   [Q1_W];

  for (genvar k = 0; k < Q1_W; k++) begin : g_d1
    logic v_i;
    gem_pkg::gem_tag_t tag_i;
    logic [CRD_W-1:0] rem_i;
    logic [Q1_W-1:0] q_i;
    logic [CRD_W:0] trial;
    logic ge;
    if (k == 0) begin : g_head
      // high digit bits start as the partial remainder, below r0 when in range
      assign v_i   = item_valid;
      assign tag_i = item.tag;
      assign rem_i = item.off[gem_pkg::OFF_W-1 -: CRD_W];
      assign q_i   = item.off[Q1_W-1:0];
    end else begin : g_link
      assign v_i   = d1_valid[k-1];
      assign tag_i = d1_tag[k-1];
      assign rem_i = d1_rem[k-1];
      assign q_i   = d1_q[k-1];
    end
    assign trial = {rem_i, q_i[Q1_W-1]};
    assign ge    = trial >= tag_i.r0;
    always_ff @(posedge clk) begin
      if (rst) d1_valid[k] <= 1'b0;
      else d1_valid[k] <= v_i;
    end
    always_ff @(posedge clk) begin
      d1_tag[k] <= tag_i;
      d1_rem[k] <= ge ? CRD_W'(trial - tag_i.r0) : CRD_W'(trial);
      d1_q[k]   <= {q_i[Q1_W-2:0], ge};
    end
  end

  // second divide of the quotient by r1
  logic [Q2_W-1:0]  d2_valid;
  gem_pkg::gem_tag_t d2_tag [Q2_W];
  logic [CRD_W-1:0] d2_c0  [Q2_W];
  logic [CRD_W-1:0] d2_rem [Q2_W];
  logic [Q2_W-1:0]  d2_q   [Q2_W];

  for (genvar k = 0; k < Q2_W; k++) begin : g_d2
    logic v_i;
    gem_pkg::gem_tag_t tag_i;
    logic [CRD_W-1:0] c0_i, rem_i;
    logic [Q2_W-1:0] q_i;
    logic [CRD_W:0] trial;
    logic ge;
    if (k == 0) begin : g_head
      assign v_i   = d1_valid[Q1_W-1];
      assign tag_i = d1_tag[Q1_W-1];
      assign c0_i  = d1_rem[Q1_W-1];
      assign rem_i = d1_q[Q1_W-1][Q1_W-1 -: CRD_W];
      assign q_i   = d1_q[Q1_W-1][Q2_W-1:0];
    end else begin : g_link
      assign v_i   = d2_valid[k-1];
      assign tag_i = d2_tag[k-1];
      assign c0_i  = d2_c0[k-1];
      assign rem_i = d2_rem[k-1];
      assign q_i   = d2_q[k-1];
    end
    assign trial = {rem_i, q_i[Q2_W-1]};
    assign ge    = trial >= tag_i.r1;
    always_ff @(posedge clk) begin
      if (rst) d2_valid[k] <= 1'b0;
      else d2_valid[k] <= v_i;
    end
    always_ff @(posedge clk) begin
      d2_tag[k] <= tag_i;
      d2_c0[k]  <= c0_i;
      d2_rem[k] <= ge ? CRD_W'(trial - tag_i.r1) : CRD_W'(trial);
      d2_q[k]   <= {q_i[Q2_W-2:0], ge};
    end
  end

  assign crd_valid = d2_valid[Q2_W-1];
  assign crd.tag   = d2_tag[Q2_W-1];
  assign crd.c0    = d2_c0[Q2_W-1];
  assign crd.c1    = d2_rem[Q2_W-1];
  assign crd.c2    = d2_q[Q2_W-1];

endmodule

`default_nettype wire

// ----- hdl/grid_edge_index_mapper.sv -----
// ----------------------------------------------------------------------------
// grid_edge_index_mapper
// index and coordinate conversion for a 3d voxel grid graph
// ----------------------------------------------------------------------------
//
//  channel   ports                                   beat taken when
//  --------  --------------------------------------  ---------------------
//  config    wr_en, wr_index, wr_data                wr_en high
//  request   start, busy, action, index_in, a_*, b_*  start high, busy low
//  result    done, index_out, src_*, dst_*, status    done high
//
// one request beat every cycle; busy never rises since nothing stalls
// the pipeline has 4 front stages (checks, two multiply levels,
// bin select), 24 divide stages (16 + 8 quotient bits), 1 output register
// the front, divide and output stages together set the latency; throughput is one beat a cycle
// rst clears the pipeline valid bits and sets every length to 256
// the result side cannot stall, a result beat is shown for one cycle only
`default_nettype none

module grid_edge_index_mapper (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                wr_en,
  input  wire logic [gem_pkg::CFG_IDX_W-1:0]       wr_index,
  input  wire logic [gem_pkg::LEN_W-1:0]           wr_data,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [1:0]                          action,
  input  wire logic [gem_pkg::IDX_W-1:0]           index_in,
  input  wire logic [gem_pkg::CRD_W-1:0]           a_x,
  input  wire logic [gem_pkg::CRD_W-1:0]           a_y,
  input  wire logic [gem_pkg::CRD_W-1:0]           a_z,
  input  wire logic [gem_pkg::CRD_W-1:0]           b_x,
  input  wire logic [gem_pkg::CRD_W-1:0]           b_y,
  input  wire logic [gem_pkg::CRD_W-1:0]           b_z,
  output logic                                     done,
  output logic [gem_pkg::IDX_W-1:0]                index_out,
  output logic [gem_pkg::CRD_W-1:0]                src_x,
  output logic [gem_pkg::CRD_W-1:0]                src_y,
  output logic [gem_pkg::CRD_W-1:0]                src_z,
  output logic [gem_pkg::CRD_W-1:0]                dst_x,
  output logic [gem_pkg::CRD_W-1:0]                dst_y,
  output logic [gem_pkg::CRD_W-1:0]                dst_z,
  output logic [1:0]                               status
);

`include "assert_macros.svh"

  localparam int CRD_W = gem_pkg::CRD_W;

  // length registers, raw values; clamping happens in the front end
  gem_pkg::gem_lens_t lens;

  always_ff @(posedge clk) begin
    if (rst) begin
      lens.x <= gem_pkg::LEN_W'(gem_pkg::MAX_LEN);
      lens.y <= gem_pkg::LEN_W'(gem_pkg::MAX_LEN);
      lens.z <= gem_pkg::LEN_W'(gem_pkg::MAX_LEN);
    end else if (wr_en) begin
      unique case (wr_index)
        gem_pkg::REG_LEN_X: lens.x <= wr_data;
        gem_pkg::REG_LEN_Y: lens.y <= wr_data;
        gem_pkg::REG_LEN_Z: lens.z <= wr_data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // fully pipelined, never holds off a request
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  logic item_valid;
  gem_pkg::gem_item_t item;

  gem_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .action     (action),
    .index_in   (index_in),
    .a_x        (a_x),
    .a_y        (a_y),
    .a_z        (a_z),
    .b_x        (b_x),
    .b_y        (b_y),
    .b_z        (b_z),
    .lens       (lens),
    .item_valid (item_valid),
    .item       (item)
  );

  logic crd_valid;
  gem_pkg::gem_coord_t crd;

  gem_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .crd_valid  (crd_valid),
    .crd        (crd)
  );

  // result formatting: source digits for vertex and edge decode, target is
  // the source stepped by one along the edge axis
  logic ok, show_src, show_dst;
  assign ok       = crd.tag.status == gem_pkg::ST_OK;
  assign show_src = ok && (crd.tag.action == gem_pkg::ACT_V2C ||
                           crd.tag.action == gem_pkg::ACT_E2P);
  assign show_dst = ok && crd.tag.action == gem_pkg::ACT_E2P;

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= crd_valid;
  end

  always_ff @(posedge clk) begin
    index_out <= crd.tag.index_out;
    status    <= crd.tag.status;
    src_x     <= show_src ? crd.c0 : '0;
    src_y     <= show_src ? crd.c1 : '0;
    src_z     <= show_src ? crd.c2 : '0;
    dst_x     <= show_dst ? crd.c0 + CRD_W'(crd.tag.axis == gem_pkg::AX_X) : '0;
    dst_y     <= show_dst ? crd.c1 + CRD_W'(crd.tag.axis == gem_pkg::AX_Y) : '0;
    dst_z     <= show_dst ? crd.c2 + CRD_W'(crd.tag.axis == gem_pkg::AX_Z) : '0;
  end

  `GEM_ASSERT_IMP(a_status_code, done, status == gem_pkg::ST_OK || status == gem_pkg::ST_NOT_ADJ || status == gem_pkg::ST_RANGE, "result beat with an undefined status code")
  `GEM_ASSERT_IMP(a_error_zero, done && status != gem_pkg::ST_OK, index_out == '0 && src_x == '0 && src_y == '0 && src_z == '0 && dst_x == '0 && dst_y == '0 && dst_z == '0, "error result beat carries nonzero fields")
  `GEM_ASSERT_NXT(a_v2c_no_dst, crd_valid && crd.tag.action == gem_pkg::ACT_V2C, dst_x == '0 && dst_y == '0 && dst_z == '0 && index_out == '0, "vertex decode beat carries target or index")

endmodule

`default_nettype wire
